FILE: rtl/noc_dor_pkg.sv
package noc_dor_pkg;

    // Mapping table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths
    localparam int SLOT_W  = 6;
    localparam int NODE_W  = 8;
    localparam int COORD_W = 4;
    localparam int SIDE_W  = 5;
    localparam int KIND_W  = 2;
    localparam int PORT_W  = 2;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_TORUS_MODE  = 3'd0;
    localparam logic [2:0] REG_OWN_X       = 3'd1;
    localparam logic [2:0] REG_OWN_Y       = 3'd2;
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd3;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd4;

    localparam logic [SIDE_W-1:0] GRID_SIDE_RESET = 5'd4;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_ROUTE = 1'b1;

    // Flit kinds
    localparam logic [KIND_W-1:0] KIND_HEAD      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BODY      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAIL      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HEAD_TAIL = 2'd3;

    // Output ports
    localparam logic [PORT_W-1:0] PORT_NORTH = 2'd0;
    localparam logic [PORT_W-1:0] PORT_SOUTH = 2'd1;
    localparam logic [PORT_W-1:0] PORT_WEST  = 2'd2;
    localparam logic [PORT_W-1:0] PORT_EAST  = 2'd3;

endpackage

FILE: rtl/noc_dor_if.sv
interface noc_dor_in_if
    import noc_dor_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               func;
    logic [SLOT_W-1:0]  entry_index;
    logic [NODE_W-1:0]  node_id;
    logic [COORD_W-1:0] entry_x;
    logic [COORD_W-1:0] entry_y;
    logic [KIND_W-1:0]  flit_kind;

    modport source
    (
        output valid, func, entry_index, node_id, entry_x, entry_y, flit_kind,
        input  ready
    );

    modport sink
    (
        input  valid, func, entry_index, node_id, entry_x, entry_y, flit_kind,
        output ready
    );
endinterface

interface noc_dor_out_if
    import noc_dor_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] out_port;
    logic              matched;
    logic              not_head_error;

    modport source
    (
        output valid, out_port, matched, not_head_error,
        input  ready
    );

    modport sink
    (
        input  valid, out_port, matched, not_head_error,
        output ready
    );
endinterface

FILE: rtl/noc_dimension_order_route.sv
// X-then-Y route computation for a network-on-chip injection port, mesh or
// torus. A write item (func 0) stores one node-id to router-coordinate entry
// in the mapping table and gives no result. A route item (func 1) scans the
// table one entry per cycle through its single read port, stops at the lowest
// valid matching slot, then resolves the port in S_CALC, which waits until
// the output register is free. A body or tail flit skips the scan and gives
// its result with the error flag set. A miss routes toward (0,0);
// a destination equal to this router gives south. The input is not ready
// while a route item is in progress; a finished result waits in the output
// register and the next item may be taken meanwhile. Registers at APB byte
// offsets 0x00 torus_mode, 0x04 own_x, 0x08 own_y, 0x0C grid_width,
// 0x10 grid_height; write them only while the block is idle.
module noc_dimension_order_route
    import noc_dor_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    noc_dor_in_if.sink          route_in,
    noc_dor_out_if.source       route_out,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;

    localparam logic [IDX_W-1:0] ADDR_LAST = IDX_W'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } entry_t;

    // Configuration registers
    logic               torus_mode_reg;
    logic [COORD_W-1:0] own_x_reg;
    logic [COORD_W-1:0] own_y_reg;
    logic [SIDE_W-1:0]  grid_width_reg;
    logic [SIDE_W-1:0]  grid_height_reg;

    // Mapping table
    entry_t                 tbl_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    entry_t                 rd_entry_reg;
    logic                   rd_vld_reg;
    logic                   rd_last_reg;

    // Sequencer
    logic [1:0]         state_reg,  state_next;
    logic [IDX_W-1:0]   addr_reg,   addr_next;
    logic               chk_reg,    chk_next;
    logic               hit_reg,    hit_next;
    logic               err_reg,    err_next;
    logic [NODE_W-1:0]  node_reg,   node_next;
    logic [COORD_W-1:0] dx_reg,     dx_next;
    logic [COORD_W-1:0] dy_reg,     dy_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [PORT_W-1:0]  out_port_reg,  out_port_next;
    logic               matched_reg,   matched_next;
    logic               nh_err_reg,    nh_err_next;

    logic               in_fire;
    logic               tbl_wr;
    logic [IDX_W-1:0]   wr_slot;
    logic               cfg_wr;
    logic               head_flit;

    // Axis unit signals
    logic               x_eq;
    logic [COORD_W-1:0] ax_dest;
    logic [COORD_W-1:0] ax_own;
    logic [SIDE_W-1:0]  ax_side;
    logic [PORT_W-1:0]  ax_low;
    logic [PORT_W-1:0]  ax_high;
    logic               ax_lt;
    logic [COORD_W-1:0] ax_dist;
    logic               ax_far;
    logic [PORT_W-1:0]  route_port;

    assign route_in.ready = (state_reg == S_IDLE);
    assign in_fire        = route_in.valid && route_in.ready;
    assign tbl_wr         = in_fire && (route_in.func == FUNC_WRITE)
                            && (int'(route_in.entry_index) < TABLE_DEPTH);
    assign wr_slot        = IDX_W'(route_in.entry_index);
    assign head_flit      = (route_in.flit_kind == KIND_HEAD)
                            || (route_in.flit_kind == KIND_HEAD_TAIL);

    assign route_out.valid          = out_valid_reg;
    assign route_out.out_port       = out_port_reg;
    assign route_out.matched        = matched_reg;
    assign route_out.not_head_error = nh_err_reg;

    // Configuration write and read-back
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torus_mode_reg  <= 1'b0;
            own_x_reg       <= '0;
            own_y_reg       <= '0;
            grid_width_reg  <= GRID_SIDE_RESET;
            grid_height_reg <= GRID_SIDE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_TORUS_MODE:  torus_mode_reg  <= pwdata[0];
                REG_OWN_X:       own_x_reg       <= pwdata[COORD_W-1:0];
                REG_OWN_Y:       own_y_reg       <= pwdata[COORD_W-1:0];
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[SIDE_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_TORUS_MODE:  prdata = PDATA_W'(torus_mode_reg);
            REG_OWN_X:       prdata = PDATA_W'(own_x_reg);
            REG_OWN_Y:       prdata = PDATA_W'(own_y_reg);
            REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    // Table valid bits: cleared by reset, set on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (tbl_wr)
        begin
            valid_reg[wr_slot] <= 1'b1;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            tbl_mem[wr_slot] <= '{node: route_in.node_id,
                                  x:    route_in.entry_x,
                                  y:    route_in.entry_y};
        end
        rd_entry_reg <= tbl_mem[addr_reg];
        rd_vld_reg   <= valid_reg[addr_reg];
        rd_last_reg  <= (addr_reg == ADDR_LAST);
    end

    // Axis unit: resolve X first, then Y
    always_comb
    begin
        x_eq    = (dx_reg == own_x_reg);
        ax_dest = x_eq ? dy_reg : dx_reg;
        ax_own  = x_eq ? own_y_reg : own_x_reg;
        ax_side = x_eq ? grid_height_reg : grid_width_reg;
        ax_low  = x_eq ? PORT_NORTH : PORT_WEST;
        ax_high = x_eq ? PORT_SOUTH : PORT_EAST;
        ax_lt   = (ax_dest < ax_own);
        ax_dist = ax_lt ? (ax_own - ax_dest) : (ax_dest - ax_own);
        ax_far  = torus_mode_reg && (ax_dist > ax_side[SIDE_W-1:1]);
        // Wraparound flips the direction
        route_port = (ax_lt != ax_far) ? ax_low : ax_high;
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        chk_next       = 1'b0;
        hit_next       = hit_reg;
        err_next       = err_reg;
        node_next      = node_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        out_valid_next = out_valid_reg && !route_out.ready;
        out_port_next  = out_port_reg;
        matched_next   = matched_reg;
        nh_err_next    = nh_err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (route_in.func == FUNC_ROUTE))
                begin
                    node_next = route_in.node_id;
                    hit_next  = 1'b0;
                    dx_next   = '0;
                    dy_next   = '0;
                    addr_next = '0;
                    if (head_flit)
                    begin
                        err_next   = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        state_next = S_CALC;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read, compare the entry read last cycle
                chk_next = 1'b1;
                if (addr_reg != ADDR_LAST)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (chk_reg)
                begin
                    if (rd_vld_reg && (rd_entry_reg.node == node_reg))
                    begin
                        hit_next   = 1'b1;
                        dx_next    = rd_entry_reg.x;
                        dy_next    = rd_entry_reg.y;
                        chk_next   = 1'b0;
                        state_next = S_CALC;
                    end
                    else if (rd_last_reg)
                    begin
                        chk_next   = 1'b0;
                        state_next = S_CALC;
                    end
                end
            end

            S_CALC:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || route_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_port_next  = err_reg ? PORT_NORTH : route_port;
                    matched_next   = hit_reg && !err_reg;
                    nh_err_next    = err_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        err_reg      <= err_next;
        node_reg     <= node_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        out_port_reg <= out_port_next;
        matched_reg  <= matched_next;
        nh_err_reg   <= nh_err_next;
    end

endmodule
